FILE: hw/rtl/vcse_pkg.sv
// Shared types and constants for the VGM command stream encoder.
package vcse_pkg;

  localparam int MaxBytes = 6;
  localparam int BodyBytes = 5;
  localparam int CountW = 3;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_PSG_WRITE = 3'd1,
    CMD_FM_WRITE  = 3'd2,
    CMD_DAC_SEEK  = 3'd3,
    CMD_DAC_DATA  = 3'd4,
    CMD_LOOP      = 3'd5,
    CMD_FINISH    = 3'd6
  } cmd_t;

  localparam logic [7:0] OP_WAIT     = 8'h61;
  localparam logic [7:0] OP_PSG      = 8'h50;
  localparam logic [7:0] OP_FM_PORT0 = 8'h52;
  localparam logic [7:0] OP_FM_PORT1 = 8'h53;
  localparam logic [7:0] OP_SEEK     = 8'hE0;
  localparam logic [7:0] OP_DAC      = 8'h80;
  localparam logic [7:0] OP_END      = 8'h66;

  localparam logic [15:0] WAIT_LIMIT = 16'hFFFF;
  localparam logic [31:0] LOOP_BIAS  = 32'h0000_001C;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] stream;
    logic [CountW-1:0]        count;
    logic [31:0]              total;
    logic [31:0]              loop_ofs;
    logic [31:0]              loop_len;
  } rec_t;

endpackage

FILE: hw/rtl/vcse_encoder.sv
// Command encoder: keeps the stream counters and turns one event into a byte record.
module vcse_encoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        cmd,
  input  logic              chip_port,
  input  logic [7:0]        register_index,
  input  logic [7:0]        write_data,
  input  logic [31:0]       seek_offset,
  output logic              rec_valid,
  input  logic              rec_ready,
  output vcse_pkg::rec_t    rec
);
  import vcse_pkg::*;

  logic [15:0] wait_count, wait_count_next, wait_inc;
  logic [31:0] sample_total, sample_total_next;
  logic [31:0] byte_count, byte_count_next;
  logic [31:0] loop_position, loop_position_next;
  logic [31:0] loop_start_sample, loop_start_sample_next;
  logic [BodyBytes-1:0][7:0] body;
  logic [CountW-1:0] body_len;
  logic flush;
  rec_t rec_next;
  logic accept;

  assign in_ready = !rec_valid || rec_ready;
  assign accept   = in_valid && in_ready;
  assign wait_inc = wait_count + 16'd1;

  always_comb begin
    body = '0;
    body_len = '0;
    flush = 1'b0;
    wait_count_next = wait_count;
    sample_total_next = sample_total;
    loop_position_next = loop_position;
    loop_start_sample_next = loop_start_sample;
    unique case (cmd_t'(cmd))
      CMD_TICK: begin
        sample_total_next = sample_total + 32'd1;
        if (wait_inc == WAIT_LIMIT) begin
          body[0] = OP_WAIT;
          body[1] = WAIT_LIMIT[7:0];
          body[2] = WAIT_LIMIT[15:8];
          body_len = CountW'(3);
          wait_count_next = '0;
        end else begin
          wait_count_next = wait_inc;
        end
      end
      CMD_PSG_WRITE: begin
        flush = (wait_count != '0);
        body[0] = OP_PSG;
        body[1] = write_data;
        body_len = CountW'(2);
      end
      CMD_FM_WRITE: begin
        flush = (wait_count != '0);
        body[0] = chip_port ? OP_FM_PORT1 : OP_FM_PORT0;
        body[1] = register_index;
        body[2] = write_data;
        body_len = CountW'(3);
      end
      CMD_DAC_SEEK: begin
        body[0] = OP_SEEK;
        body[1] = seek_offset[7:0];
        body[2] = seek_offset[15:8];
        body[3] = seek_offset[23:16];
        body[4] = seek_offset[31:24];
        body_len = CountW'(5);
      end
      CMD_DAC_DATA: begin
        flush = (wait_count != '0);
        body[0] = OP_DAC;
        body_len = CountW'(1);
      end
      CMD_LOOP: begin
        loop_position_next = byte_count - LOOP_BIAS;
        loop_start_sample_next = sample_total;
      end
      CMD_FINISH: begin
        body[0] = OP_END;
        body_len = CountW'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rec_next = '0;
    if (flush) begin
      rec_next.stream[0] = OP_WAIT;
      rec_next.stream[1] = wait_count[7:0];
      rec_next.stream[2] = wait_count[15:8];
      rec_next.stream[3] = body[0];
      rec_next.stream[4] = body[1];
      rec_next.stream[5] = body[2];
      rec_next.count = body_len + CountW'(3);
    end else begin
      rec_next.stream[4:0] = body;
      rec_next.count = body_len;
    end
    rec_next.total = sample_total_next;
    rec_next.loop_ofs = loop_position_next;
    rec_next.loop_len = sample_total_next - loop_start_sample_next;
  end

  assign byte_count_next = byte_count + 32'(rec_next.count);

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_count <= '0;
      sample_total <= '0;
      byte_count <= '0;
      loop_position <= '0;
      loop_start_sample <= '0;
      rec_valid <= 1'b0;
    end else begin
      if (accept) begin
        wait_count <= flush ? '0 : wait_count_next;
        sample_total <= sample_total_next;
        byte_count <= byte_count_next;
        loop_position <= loop_position_next;
        loop_start_sample <= loop_start_sample_next;
        rec_valid <= (rec_next.count != '0);
      end else if (rec_valid && rec_ready) begin
        rec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rec <= rec_next;
    end
  end

  a_rec_nonempty: assert property (@(posedge clk) disable iff (rst)
    rec_valid |-> (rec.count != '0) && (rec.count <= CountW'(MaxBytes)))
    else $error("Held record has an invalid byte count.");

  a_wait_below_limit: assert property (@(posedge clk) disable iff (rst)
    wait_count != WAIT_LIMIT)
    else $error("Pending wait reached the limit without a flush.");

  a_bytes_counted: assert property (@(posedge clk) disable iff (rst)
    accept |=> byte_count == $past(byte_count) + 32'($past(rec_next.count)))
    else $error("Byte position does not follow the emitted bytes.");

endmodule

FILE: hw/rtl/vcse_serializer.sv
// Byte serializer: sends the bytes of each record one transfer at a time.
module vcse_serializer (
  input  logic              clk,
  input  logic              rst,
  input  logic              rec_valid,
  output logic              rec_ready,
  input  vcse_pkg::rec_t    rec,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              last_byte,
  output logic [31:0]       total_samples,
  output logic signed [31:0] loop_offset,
  output logic [31:0]       loop_samples
);
  import vcse_pkg::*;

  rec_t cur;
  logic cur_valid;
  logic [CountW-1:0] idx;
  logic take, is_last;

  assign out_valid = cur_valid;
  assign take = cur_valid && out_ready;
  assign is_last = (idx == cur.count - CountW'(1));
  assign rec_ready = !cur_valid || (take && is_last);

  assign out_byte = cur.stream[idx];
  assign last_byte = is_last;
  assign total_samples = cur.total;
  assign loop_offset = $signed(cur.loop_ofs);
  assign loop_samples = cur.loop_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= '0;
    end else if (rec_ready) begin
      cur_valid <= rec_valid;
      idx <= '0;
    end else if (take) begin
      idx <= idx + CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rec_ready && rec_valid) begin
      cur <= rec;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.count != '0) && (idx < cur.count))
    else $error("Byte index runs past the record.");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (take && !is_last) |=> out_valid && (idx == $past(idx) + CountW'(1)))
    else $error("Serializer did not advance to the next byte.");

  a_load: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && rec_ready) |=> out_valid && (idx == '0))
    else $error("New record did not start at its first byte.");

endmodule

FILE: hw/rtl/vgm_command_stream_encoder.sv
// Top level of the VGM command stream encoder.
//
// Events enter on the input channel (in_valid/in_ready with cmd, chip_port,
// register_index, write_data and seek_offset). Each event is encoded into a
// record of zero to six command bytes, held in a record register, and then
// sent one byte per transfer on the output channel (out_valid/out_ready with
// out_byte, last_byte and the counter fields). Ticks and loop points usually
// produce no bytes and only update counters. The first byte of an event passes
// through the record register and then the serializer's current record before
// it appears. The output moves one byte per cycle while out_ready is high, so
// the sustained rate is set by the serializer, and an event with no bytes
// only takes an input transfer. The next event is taken while the previous
// one is still being sent, so back-to-back events keep the output busy every
// cycle. When the receiver stalls, the current byte holds, the record
// register fills and then in_ready drops. Reset clears the wait count, sample
// total, byte position and loop marks to zero and empties both stages.
module vgm_command_stream_encoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         cmd,
  input  logic               chip_port,
  input  logic [7:0]         register_index,
  input  logic [7:0]         write_data,
  input  logic [31:0]        seek_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               last_byte,
  output logic [31:0]        total_samples,
  output logic signed [31:0] loop_offset,
  output logic [31:0]        loop_samples
);
  import vcse_pkg::*;

  rec_t rec;
  logic rec_valid, rec_ready;

  vcse_encoder u_encoder (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .chip_port      (chip_port),
    .register_index (register_index),
    .write_data     (write_data),
    .seek_offset    (seek_offset),
    .rec_valid      (rec_valid),
    .rec_ready      (rec_ready),
    .rec            (rec)
  );

  vcse_serializer u_serializer (
    .clk           (clk),
    .rst           (rst),
    .rec_valid     (rec_valid),
    .rec_ready     (rec_ready),
    .rec           (rec),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_byte     (last_byte),
    .total_samples (total_samples),
    .loop_offset   (loop_offset),
    .loop_samples  (loop_samples)
  );

endmodule
